@@ hdl/pia_pkg.sv @@
// shared types, codes and constants of the pulse id aligner
package pia_pkg;

    localparam int ID_W     = 64;
    localparam int SKIP_W   = 32;
    localparam int RETRY_W  = 8;
    localparam int COUNT_W  = 6;
    localparam int WANT_W   = 5;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd2;

    localparam logic [COUNT_W-1:0] MODULE_COUNT_RST = 6'd1;
    localparam logic [CFG_W-1:0]   OFFSET_LIMIT_RST = 32'd1000;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST  = 8'd5;

    localparam logic [SKIP_W-1:0]  SKIP_SAT  = '1;
    localparam logic [RETRY_W-1:0] ROUND_SAT = '1;

    typedef enum logic [1:0] {
        ST_NEED    = 2'd0,
        ST_ALIGNED = 2'd1,
        ST_OFFSET  = 2'd2,
        ST_RETRY   = 2'd3
    } status_t;

    typedef enum logic {
        PH_GATHER,
        PH_CATCHUP
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_ADV,
        S_ADV_CHK,
        S_SCAN,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [WANT_W-1:0]   want_module;
        logic [ID_W-1:0]     aligned_id;
        logic [SKIP_W-1:0]   lost_pulses;
    } res_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    function automatic res_t make_res(input status_t st, input logic [WANT_W-1:0] want,
                                      input logic [ID_W-1:0] id,
                                      input logic [SKIP_W-1:0] lost);
        res_t r;
        r.status      = st;
        r.want_module = want;
        r.aligned_id  = id;
        r.lost_pulses = lost;
        return r;
    endfunction

endpackage

@@ hdl/pia_head_ram.sv @@
// module head memory, one write and one registered read port
module pia_head_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [pia_pkg::ID_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [pia_pkg::ID_W-1:0] rdata
);
    import pia_pkg::*;

    logic [ID_W-1:0] mem_reg [DEPTH];
    logic [ID_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pia_minmax.sv @@
// running minimum and maximum of the head ids read during a round start
module pia_minmax (
    input  logic                      aclk,
    input  pia_pkg::scan_ctl_t        ctl,
    input  logic [pia_pkg::ID_W-1:0]  data,
    output logic [pia_pkg::ID_W-1:0]  lo,
    output logic [pia_pkg::ID_W-1:0]  hi
);
    import pia_pkg::*;

    logic [ID_W-1:0] lo_reg;
    logic [ID_W-1:0] hi_reg;

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            lo_reg <= '1;
            hi_reg <= '0;
        end else if (ctl.sample) begin
            if (data < lo_reg) begin
                lo_reg <= data;
            end
            if (data > hi_reg) begin
                hi_reg <= data;
            end
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

@@ hdl/pia_ctrl.sv @@
// alignment sequencer: gather, round start scan, catch-up and result register
module pia_ctrl #(
    parameter int MAX_MODULES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pia_pkg::COUNT_W-1:0]   cfg_module_count,
    input  logic [pia_pkg::CFG_W-1:0]     cfg_offset_limit,
    input  logic [pia_pkg::RETRY_W-1:0]   cfg_retry_limit,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pia_pkg::ID_W-1:0]      s_pulse_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pia_pkg::res_t                 m_res,
    output logic                          ram_we,
    output logic [((MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1)-1:0] ram_waddr,
    output logic [pia_pkg::ID_W-1:0]      ram_wdata,
    output logic                          ram_re,
    output logic [((MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1)-1:0] ram_raddr,
    input  logic [pia_pkg::ID_W-1:0]      ram_rdata,
    output pia_pkg::scan_ctl_t            scan_ctl,
    input  logic [pia_pkg::ID_W-1:0]      scan_lo,
    input  logic [pia_pkg::ID_W-1:0]      scan_hi
);
    import pia_pkg::*;

    localparam int AW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int CW = $clog2(MAX_MODULES + 1);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       cm_reg, cm_next;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic [ID_W-1:0]     target_reg, target_next;
    logic                all_eq_reg, all_eq_next;
    logic [RETRY_W-1:0]  rc_reg, rc_next;
    logic [SKIP_W-1:0]   mskip_reg, mskip_next;
    logic [SKIP_W-1:0]   rskip_reg, rskip_next;
    logic [SKIP_W-1:0]   total_reg, total_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [ID_W-1:0]     head0_reg, head0_next;
    res_t                res_reg, res_next;
    res_t                m_res_reg, m_res_next;

    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       cm_inc;
    logic [SKIP_W-1:0]   mskip_inc;
    logic [SKIP_W:0]     total_sum;
    logic [SKIP_W-1:0]   total_sat;
    logic [RETRY_W-1:0]  rc_inc;

    // zero acts as one module, anything beyond the memory as all of it
    always_comb begin
        if (cfg_module_count == '0) begin
            n_eff = CW'(1);
        end else if (int'(cfg_module_count) > MAX_MODULES) begin
            n_eff = CW'(MAX_MODULES);
        end else begin
            n_eff = CW'(cfg_module_count);
        end
    end

    assign cm_inc    = cm_reg + 1'b1;
    assign mskip_inc = (mskip_reg == SKIP_SAT) ? mskip_reg : mskip_reg + 1'b1;
    assign total_sum = {1'b0, total_reg} + {1'b0, rskip_reg};
    assign total_sat = total_sum[SKIP_W] ? SKIP_SAT : total_sum[SKIP_W-1:0];
    assign rc_inc    = (rc_reg == ROUND_SAT) ? rc_reg : rc_reg + 1'b1;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_GATHER;
            cm_reg       <= '0;
            scan_idx_reg <= '0;
            target_reg   <= '0;
            all_eq_reg   <= 1'b1;
            rc_reg       <= '0;
            mskip_reg    <= '0;
            rskip_reg    <= '0;
            total_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cm_reg       <= cm_next;
            scan_idx_reg <= scan_idx_next;
            target_reg   <= target_next;
            all_eq_reg   <= all_eq_next;
            rc_reg       <= rc_next;
            mskip_reg    <= mskip_next;
            rskip_reg    <= rskip_next;
            total_reg    <= total_next;
            rd_vld_reg   <= rd_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        head0_reg <= head0_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cm_next       = cm_reg;
        scan_idx_next = scan_idx_reg;
        target_next   = target_reg;
        all_eq_next   = all_eq_reg;
        rc_next       = rc_reg;
        mskip_next    = mskip_reg;
        rskip_next    = rskip_reg;
        total_next    = total_reg;
        rd_vld_next   = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        id_next       = id_reg;
        head0_next    = head0_reg;
        res_next      = res_reg;
        m_res_next    = m_res_reg;
        ram_we        = 1'b0;
        ram_waddr     = cm_reg[AW-1:0];
        ram_wdata     = id_reg;
        ram_re        = 1'b0;
        ram_raddr     = cm_reg[AW-1:0];
        scan_ctl      = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    id_next    = s_pulse_id;
                    state_next = S_PROC;
                end
            end

            S_PROC: begin
                if (phase_reg == PH_GATHER) begin
                    ram_we = 1'b1;
                    if (cm_reg == '0) begin
                        head0_next = id_reg;
                    end else if (id_reg != head0_reg) begin
                        all_eq_next = 1'b0;
                    end
                    cm_next = cm_inc;
                    if (cm_inc < n_eff) begin
                        res_next   = make_res(ST_NEED, WANT_W'(cm_inc), '0, '0);
                        state_next = S_OUT;
                    end else if (all_eq_next) begin
                        res_next   = make_res(ST_ALIGNED, '0, head0_next, '0);
                        state_next = S_OUT;
                    end else if (rc_reg >= cfg_retry_limit) begin
                        res_next   = make_res(ST_RETRY, '0, '0, '0);
                        state_next = S_OUT;
                    end else begin
                        scan_ctl.clear = 1'b1;
                        scan_idx_next  = '0;
                        state_next     = S_SCAN;
                    end
                end else if (cm_reg < n_eff) begin
                    ram_we = 1'b1;
                    if (cm_reg == '0) begin
                        head0_next = id_reg;
                    end
                    if (id_reg < target_reg) begin
                        mskip_next = mskip_inc;
                        res_next   = make_res(ST_NEED, WANT_W'(cm_reg), '0, '0);
                        state_next = S_OUT;
                    end else begin
                        if (mskip_inc > rskip_reg) begin
                            rskip_next = mskip_inc;
                        end
                        if (id_reg != target_reg) begin
                            all_eq_next = 1'b0;
                        end
                        mskip_next = '0;
                        cm_next    = cm_inc;
                        state_next = S_ADV;
                    end
                end else begin
                    state_next = S_ADV;
                end
            end

            S_ADV: begin
                if (cm_reg < n_eff) begin
                    ram_re     = 1'b1;
                    state_next = S_ADV_CHK;
                end else begin
                    total_next = total_sat;
                    rc_next    = rc_inc;
                    if (all_eq_reg) begin
                        res_next   = make_res(ST_ALIGNED, '0, head0_reg, total_sat);
                        state_next = S_OUT;
                    end else if (rc_inc >= cfg_retry_limit) begin
                        res_next   = make_res(ST_RETRY, '0, '0, '0);
                        state_next = S_OUT;
                    end else begin
                        scan_ctl.clear = 1'b1;
                        scan_idx_next  = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_ADV_CHK: begin
                if (ram_rdata >= target_reg) begin
                    if (ram_rdata != target_reg) begin
                        all_eq_next = 1'b0;
                    end
                    cm_next    = cm_inc;
                    state_next = S_ADV;
                end else begin
                    res_next   = make_res(ST_NEED, WANT_W'(cm_reg), '0, '0);
                    state_next = S_OUT;
                end
            end

            S_SCAN: begin
                scan_ctl.sample = rd_vld_reg;
                if (scan_idx_reg < n_eff) begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_vld_next   = 1'b1;
                end else if (!rd_vld_reg) begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                if ((scan_hi - scan_lo) > ID_W'(cfg_offset_limit)) begin
                    res_next   = make_res(ST_OFFSET, '0, '0, '0);
                    state_next = S_OUT;
                end else begin
                    target_next = scan_hi;
                    all_eq_next = 1'b1;
                    rskip_next  = '0;
                    mskip_next  = '0;
                    cm_next     = '0;
                    phase_next  = PH_CATCHUP;
                    state_next  = S_ADV;
                end
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_res_next   = res_reg;
                    m_valid_next = 1'b1;
                    // final result: back to gathering from module zero
                    if (res_reg.status != ST_NEED) begin
                        phase_next  = PH_GATHER;
                        cm_next     = '0;
                        all_eq_next = 1'b1;
                        rc_next     = '0;
                        mskip_next  = '0;
                        rskip_next  = '0;
                        total_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/multi_module_pulse_id_aligner_core.sv @@
// top level of the multi-module pulse id aligner
//
// Aligns the pulse id streams of up to MAX_MODULES detector modules. Every input
// transaction carries the next pulse id of the module named by the last result
// with status "need word" (module zero after reset and after any final result),
// and every input transaction yields exactly one result transaction. A plain
// gather or catch-up word passes through the processing and output states into
// the output register; a catch-up word that finishes a module adds one read of
// the head memory plus a compare for every further module head that has to be
// checked against the round target. Ending a round and starting the next one
// scans all module heads through the single read port of the head memory before
// the spread is checked. Results leave through an output register, and a new
// transaction is taken once its result is placed there.
module multi_module_pulse_id_aligner_core #(
    parameter int MAX_MODULES = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pia_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pia_pkg::ID_W-1:0]        s_pulse_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [pia_pkg::WANT_W-1:0]      m_want_module,
    output logic [pia_pkg::ID_W-1:0]        m_aligned_id,
    output logic [pia_pkg::SKIP_W-1:0]      m_lost_pulses
);
    import pia_pkg::*;

    localparam int AW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

    logic [COUNT_W-1:0] module_count_reg;
    logic [CFG_W-1:0]   offset_limit_reg;
    logic [RETRY_W-1:0] retry_limit_reg;

    res_t               m_res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ID_W-1:0]    ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ID_W-1:0]    ram_rdata;
    scan_ctl_t          scan_ctl;
    logic [ID_W-1:0]    scan_lo;
    logic [ID_W-1:0]    scan_hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_count_reg <= MODULE_COUNT_RST;
            offset_limit_reg <= OFFSET_LIMIT_RST;
            retry_limit_reg  <= RETRY_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODULE_COUNT: module_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_OFFSET_LIMIT: offset_limit_reg <= cfg_data;
                CFG_RETRY_LIMIT:  retry_limit_reg  <= cfg_data[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pia_head_ram #(
        .DEPTH (MAX_MODULES),
        .AW    (AW)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pia_minmax u_minmax (
        .aclk (aclk),
        .ctl  (scan_ctl),
        .data (ram_rdata),
        .lo   (scan_lo),
        .hi   (scan_hi)
    );

    pia_ctrl #(
        .MAX_MODULES (MAX_MODULES)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_module_count (module_count_reg),
        .cfg_offset_limit (offset_limit_reg),
        .cfg_retry_limit  (retry_limit_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pulse_id       (s_pulse_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_res            (m_res),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .scan_ctl         (scan_ctl),
        .scan_lo          (scan_lo),
        .scan_hi          (scan_hi)
    );

    assign m_status      = m_res.status;
    assign m_want_module = m_res.want_module;
    assign m_aligned_id  = m_res.aligned_id;
    assign m_lost_pulses = m_res.lost_pulses;

endmodule

@@ hdl/pia_checker.sv @@
// port-level checks of the pulse id aligner and their binding to the top level
module pia_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_status,
    input  logic [pia_pkg::WANT_W-1:0]      m_want_module,
    input  logic [pia_pkg::ID_W-1:0]        m_aligned_id,
    input  logic [pia_pkg::SKIP_W-1:0]      m_lost_pulses
);
    import pia_pkg::*;

    // need-word results carry no id and no lost count
    a_need_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_NEED) |-> (m_aligned_id == '0 && m_lost_pulses == '0))
        else $error("need-word result with nonzero id or lost count");

    // final results point at no module
    a_final_want_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_NEED) |-> (m_want_module == '0))
        else $error("final result with nonzero module index");

    // error results carry no id and no lost count
    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_OFFSET || m_status == ST_RETRY))
            |-> (m_aligned_id == '0 && m_lost_pulses == '0))
        else $error("error result with nonzero id or lost count");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a transaction");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_aligned_id)
            && $stable(m_want_module) && $stable(m_lost_pulses)))
        else $error("stalled result changed");

endmodule

bind multi_module_pulse_id_aligner_core pia_checker u_pia_checker (.*);
